### src/tdr_pkg.sv
// Shared types, constants and ramp helpers for the teleoperation drive ramp.
package tdr_pkg;

    // Item kinds.
    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_STOP = 2'd1;
    localparam logic [1:0] KIND_LINK = 2'd2;
    localparam logic [1:0] KIND_FACE = 2'd3;

    // Face codes.
    localparam logic [1:0] FACE_IDLE   = 2'd0;
    localparam logic [1:0] FACE_LINKED = 2'd1;
    localparam logic [1:0] FACE_HAPPY  = 2'd2;
    localparam logic [1:0] FACE_ANGRY  = 2'd3;

    // Configuration register indexes and address width.
    localparam int         ADDR_W          = 5;
    localparam logic [2:0] REG_MOOD_HOLD   = 3'd0;
    localparam logic [2:0] REG_MOVE_ACCEL  = 3'd1;
    localparam logic [2:0] REG_MOVE_BRAKE  = 3'd2;
    localparam logic [2:0] REG_TURN_DEAD   = 3'd3;
    localparam logic [2:0] REG_TURN_ACCEL  = 3'd4;
    localparam logic [2:0] REG_TURN_LIMIT  = 3'd5;

    // Register reset values.
    localparam logic [15:0] RST_MOOD_HOLD  = 16'd100;
    localparam logic [6:0]  RST_MOVE_ACCEL = 7'd2;
    localparam logic [6:0]  RST_MOVE_BRAKE = 7'd5;
    localparam logic [6:0]  RST_TURN_DEAD  = 7'd3;
    localparam logic [6:0]  RST_TURN_ACCEL = 7'd6;
    localparam logic [11:0] RST_TURN_LIMIT = 12'd1000;

    // Datapath constants.
    localparam logic signed [9:0] DRIVE_MAX  = 10'sd127;
    localparam logic [9:0]        PITCH_MAX  = 10'd850;
    localparam logic [9:0]        PITCH_STOP = 10'd550;
    // ceil(2^16 / 6); exact floor division for magnitudes up to 4095.
    localparam logic [13:0]       DIV6_RECIP = 14'd10923;

    typedef struct packed {
        logic [15:0] mood_hold_ticks;
        logic [6:0]  move_accel;
        logic [6:0]  move_brake;
        logic [6:0]  turn_dead_zone;
        logic [6:0]  turn_accel;
        logic [11:0] turn_limit;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         kind;
        logic               key_left;
        logic               key_right;
        logic               key_up;
        logic               key_down;
        logic signed [15:0] mouse_dx;
        logic signed [15:0] mouse_dy;
        logic               link_up;
        logic [1:0]         mood;
    } t_in_item;

    typedef struct packed {
        logic signed [7:0] strafe_drive;
        logic signed [7:0] move_drive;
        logic signed [7:0] turn_drive;
        logic [9:0]        camera_pitch;
        logic [1:0]        face;
    } t_out_item;

    // Raise a level by acc, saturating at the drive maximum.
    function automatic logic signed [9:0] push_up(input logic signed [9:0] v,
                                                  input logic [6:0] acc);
        logic signed [9:0] a;
        a = $signed({3'b000, acc});
        return (v < (DRIVE_MAX - a)) ? v + a : DRIVE_MAX;
    endfunction

    // Lower a level by acc, saturating at the negative drive maximum.
    function automatic logic signed [9:0] push_down(input logic signed [9:0] v,
                                                    input logic [6:0] acc);
        logic signed [9:0] a;
        a = $signed({3'b000, acc});
        return (v > -(DRIVE_MAX - a)) ? v - a : -DRIVE_MAX;
    endfunction

endpackage

### src/teleop_drive_ramp.sv
// Top level of the teleoperation drive ramp: handshakes, state and event decode.
//
//   channel   direction  handshake                       payload
//   -------   ---------  ------------------------------  ----------------------
//   in        sink       i_in_valid / o_in_stall         i_in_data  (t_in_item)
//   out       source     o_out_valid / i_out_stall       o_out_data (t_out_item)
//   config    sink       psel, penable, pwrite, pready   paddr, pwdata, prdata
//
// One item per clock cycle sustained while the output is not stalled; each item
// is held in the input register and its result is then registered in the output
// register. The state update is a single combinational pass.
// Reset is synchronous, active low, and clears all levels, the link and face.
// A stalled output holds its result while one more item waits in the input
// register; only then does the input side stall.
module teleop_drive_ramp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tdr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  tdr_pkg::t_in_item          i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output tdr_pkg::t_out_item         o_out_data
);

    tdr_pkg::t_cfg      w_cfg;

    tdr_pkg::t_in_item  r_in;
    logic               r_in_vld;
    tdr_pkg::t_out_item r_out;
    logic               r_out_vld;

    logic signed [7:0]  r_strafe;
    logic signed [7:0]  r_move;
    logic signed [7:0]  r_turn;
    logic [9:0]         r_pitch;
    logic signed [12:0] r_integral;
    logic               r_linked;
    logic [1:0]         r_face;
    logic [15:0]        r_face_timer;

    logic signed [7:0]  n_strafe;
    logic signed [7:0]  n_move;
    logic signed [7:0]  n_turn;
    logic [9:0]         n_pitch;
    logic signed [12:0] n_integral;
    logic               n_linked;
    logic [1:0]         n_face;
    logic [15:0]        n_face_timer;

    logic               w_out_free;
    logic               w_exec;
    logic               w_in_acc;

    logic signed [7:0]  w_strafe_tick;
    logic signed [7:0]  w_move_tick;
    logic signed [7:0]  w_turn_tick;
    logic signed [12:0] w_integral_tick;
    logic signed [17:0] w_pitch_sum;
    logic [9:0]         w_pitch_tick;

    tdr_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    tdr_ramp_axis u_strafe (
        .i_level   (r_strafe),
        .i_neg_key (r_in.key_left),
        .i_pos_key (r_in.key_right),
        .i_accel   (w_cfg.move_accel),
        .i_brake   (w_cfg.move_brake),
        .o_level   (w_strafe_tick)
    );

    tdr_ramp_axis u_move (
        .i_level   (r_move),
        .i_neg_key (r_in.key_up),
        .i_pos_key (r_in.key_down),
        .i_accel   (w_cfg.move_accel),
        .i_brake   (w_cfg.move_brake),
        .o_level   (w_move_tick)
    );

    tdr_turn_ctrl u_turn (
        .i_integral (r_integral),
        .i_level    (r_turn),
        .i_dx       (r_in.mouse_dx),
        .i_cfg      (w_cfg),
        .o_integral (w_integral_tick),
        .o_level    (w_turn_tick)
    );

    // Handshake: the output register frees when empty or when its transfer completes.
    assign w_out_free  = !r_out_vld || !i_out_stall;
    assign w_exec      = r_in_vld && w_out_free;
    assign o_in_stall  = r_in_vld && !w_out_free;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    assign w_pitch_sum = $signed({8'd0, r_pitch})
                         + {{2{r_in.mouse_dy[15]}}, r_in.mouse_dy};

    always_comb begin
        if (w_pitch_sum > $signed({8'd0, tdr_pkg::PITCH_MAX})) begin
            w_pitch_tick = tdr_pkg::PITCH_MAX;
        end else if (w_pitch_sum < 18'sd0) begin
            w_pitch_tick = 10'd0;
        end else begin
            w_pitch_tick = w_pitch_sum[9:0];
        end
    end

    always_comb begin
        n_strafe     = r_strafe;
        n_move       = r_move;
        n_turn       = r_turn;
        n_pitch      = r_pitch;
        n_integral   = r_integral;
        n_linked     = r_linked;
        n_face       = r_face;
        n_face_timer = r_face_timer;
        unique case (r_in.kind)
            tdr_pkg::KIND_TICK: begin
                if (r_linked) begin
                    // The face falls back to connected as the timer runs out.
                    if (r_face_timer != 16'd0) begin
                        n_face_timer = r_face_timer - 16'd1;
                        if (r_face_timer == 16'd1) begin
                            n_face = tdr_pkg::FACE_LINKED;
                        end
                    end
                    n_strafe   = w_strafe_tick;
                    n_move     = w_move_tick;
                    n_turn     = w_turn_tick;
                    n_integral = w_integral_tick;
                    n_pitch    = w_pitch_tick;
                end
            end
            tdr_pkg::KIND_STOP: begin
                n_strafe   = 8'sd0;
                n_move     = 8'sd0;
                n_turn     = 8'sd0;
                n_integral = 13'sd0;
                n_pitch    = tdr_pkg::PITCH_STOP;
            end
            tdr_pkg::KIND_LINK: begin
                n_linked = r_in.link_up;
                n_face   = r_in.link_up ? tdr_pkg::FACE_LINKED : tdr_pkg::FACE_IDLE;
            end
            tdr_pkg::KIND_FACE: begin
                if (r_in.mood == tdr_pkg::FACE_HAPPY || r_in.mood == tdr_pkg::FACE_ANGRY) begin
                    n_face       = r_in.mood;
                    n_face_timer = w_cfg.mood_hold_ticks;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
            r_strafe     <= 8'sd0;
            r_move       <= 8'sd0;
            r_turn       <= 8'sd0;
            r_pitch      <= 10'd0;
            r_integral   <= 13'sd0;
            r_linked     <= 1'b0;
            r_face       <= tdr_pkg::FACE_IDLE;
            r_face_timer <= 16'd0;
        end else begin
            if (w_in_acc) begin
                r_in_vld <= 1'b1;
            end else if (w_exec) begin
                r_in_vld <= 1'b0;
            end

            if (w_exec) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end

            if (w_exec) begin
                r_strafe     <= n_strafe;
                r_move       <= n_move;
                r_turn       <= n_turn;
                r_pitch      <= n_pitch;
                r_integral   <= n_integral;
                r_linked     <= n_linked;
                r_face       <= n_face;
                r_face_timer <= n_face_timer;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in <= i_in_data;
        end
        if (w_exec) begin
            r_out.strafe_drive <= n_strafe;
            r_out.move_drive   <= n_move;
            r_out.turn_drive   <= n_turn;
            r_out.camera_pitch <= n_pitch;
            r_out.face         <= n_face;
        end
    end

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pitch <= tdr_pkg::PITCH_MAX)
        else $error("camera pitch left its range");

    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strafe != -8'sd128 && r_move != -8'sd128 && r_turn != -8'sd128)
        else $error("drive level reached -128");

    a_stop_pitch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_exec && r_in.kind == tdr_pkg::KIND_STOP) |=> r_pitch == tdr_pkg::PITCH_STOP)
        else $error("stop did not park the camera pitch");

    a_idle_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_exec && r_in.kind == tdr_pkg::KIND_TICK && !r_linked)
        |=> $stable(r_strafe) && $stable(r_turn) && $stable(r_pitch) && $stable(r_face))
        else $error("tick changed state while disconnected");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exec |=> r_out_vld)
        else $error("executed item produced no result");

endmodule

### src/tdr_cfg_regs.sv
// APB-style configuration register file for the drive ramp.
module tdr_cfg_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tdr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output tdr_pkg::t_cfg              o_cfg
);

    tdr_pkg::t_cfg r_cfg;
    logic          w_wr;
    logic [2:0]    w_idx;

    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[4:2];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mood_hold_ticks <= tdr_pkg::RST_MOOD_HOLD;
            r_cfg.move_accel      <= tdr_pkg::RST_MOVE_ACCEL;
            r_cfg.move_brake      <= tdr_pkg::RST_MOVE_BRAKE;
            r_cfg.turn_dead_zone  <= tdr_pkg::RST_TURN_DEAD;
            r_cfg.turn_accel      <= tdr_pkg::RST_TURN_ACCEL;
            r_cfg.turn_limit      <= tdr_pkg::RST_TURN_LIMIT;
        end else if (w_wr) begin
            unique case (w_idx)
                tdr_pkg::REG_MOOD_HOLD:  r_cfg.mood_hold_ticks <= pwdata[15:0];
                tdr_pkg::REG_MOVE_ACCEL: r_cfg.move_accel      <= pwdata[6:0];
                tdr_pkg::REG_MOVE_BRAKE: r_cfg.move_brake      <= pwdata[6:0];
                tdr_pkg::REG_TURN_DEAD:  r_cfg.turn_dead_zone  <= pwdata[6:0];
                tdr_pkg::REG_TURN_ACCEL: r_cfg.turn_accel      <= pwdata[6:0];
                tdr_pkg::REG_TURN_LIMIT: r_cfg.turn_limit      <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            tdr_pkg::REG_MOOD_HOLD:  prdata = {16'd0, r_cfg.mood_hold_ticks};
            tdr_pkg::REG_MOVE_ACCEL: prdata = {25'd0, r_cfg.move_accel};
            tdr_pkg::REG_MOVE_BRAKE: prdata = {25'd0, r_cfg.move_brake};
            tdr_pkg::REG_TURN_DEAD:  prdata = {25'd0, r_cfg.turn_dead_zone};
            tdr_pkg::REG_TURN_ACCEL: prdata = {25'd0, r_cfg.turn_accel};
            tdr_pkg::REG_TURN_LIMIT: prdata = {20'd0, r_cfg.turn_limit};
            default:                 prdata = 32'd0;
        endcase
    end

endmodule

### src/tdr_ramp_axis.sv
// One key-driven axis: accelerate on held keys, brake toward zero on release.
module tdr_ramp_axis (
    input  logic signed [7:0] i_level,
    input  logic              i_neg_key,
    input  logic              i_pos_key,
    input  logic [6:0]        i_accel,
    input  logic [6:0]        i_brake,
    output logic signed [7:0] o_level
);

    logic signed [9:0] w_v0;
    logic signed [9:0] w_v1;
    logic signed [9:0] w_v2;
    logic signed [9:0] w_brake;

    assign w_v0    = {{2{i_level[7]}}, i_level};
    assign w_brake = $signed({3'b000, i_brake});

    // The negative key is applied first, then the positive key sees its result.
    always_comb begin
        if (i_neg_key) begin
            w_v1 = tdr_pkg::push_down(w_v0, i_accel);
        end else if (w_v0 < 10'sd0) begin
            w_v1 = (w_v0 < -w_brake) ? w_v0 + w_brake : 10'sd0;
        end else begin
            w_v1 = w_v0;
        end

        if (i_pos_key) begin
            w_v2 = tdr_pkg::push_up(w_v1, i_accel);
        end else if (w_v1 > 10'sd0) begin
            w_v2 = (w_v1 > w_brake) ? w_v1 - w_brake : 10'sd0;
        end else begin
            w_v2 = w_v1;
        end
    end

    assign o_level = w_v2[7:0];

endmodule

### src/tdr_turn_ctrl.sv
// Turn integrator with clamp, and the turn drive with dead zone, ramp and cap.
module tdr_turn_ctrl (
    input  logic signed [12:0] i_integral,
    input  logic signed [7:0]  i_level,
    input  logic signed [15:0] i_dx,
    input  tdr_pkg::t_cfg      i_cfg,
    output logic signed [12:0] o_integral,
    output logic signed [7:0]  o_level
);

    logic signed [14:0] w_twice;
    logic signed [14:0] w_half_full;
    logic signed [13:0] w_half;
    logic signed [17:0] w_sum;
    logic signed [17:0] w_lim;
    logic signed [17:0] w_int;
    logic signed [17:0] w_int_neg;
    logic signed [17:0] w_dz;
    logic [11:0]        w_mag;
    logic [25:0]        w_prod;
    logic [9:0]         w_quot;
    logic [10:0]        w_cap;
    logic signed [11:0] w_cap_pos;
    logic signed [11:0] w_cap_neg;
    logic signed [9:0]  w_lvl;
    logic signed [9:0]  w_up;
    logic signed [9:0]  w_down;
    logic signed [11:0] w_up_x;
    logic signed [11:0] w_down_x;

    // Leak half the current turn out of the integrator, rounding toward zero.
    assign w_twice     = $signed({i_integral[12], i_integral, 1'b0})
                         - $signed({{7{i_level[7]}}, i_level});
    assign w_half_full = (w_twice + (w_twice[14] ? 15'sd1 : 15'sd0)) >>> 1;
    assign w_half      = w_half_full[13:0];
    assign w_sum       = {{4{w_half[13]}}, w_half} + {{2{i_dx[15]}}, i_dx};
    assign w_lim       = $signed({6'd0, i_cfg.turn_limit});

    always_comb begin
        if (w_sum > w_lim) begin
            w_int = w_lim;
        end else if (w_sum < -w_lim) begin
            w_int = -w_lim;
        end else begin
            w_int = w_sum;
        end
    end

    assign o_integral = w_int[12:0];
    assign w_int_neg  = -w_int;

    // Magnitude divided by six through a reciprocal multiply.
    assign w_mag     = w_int[17] ? w_int_neg[11:0] : w_int[11:0];
    assign w_prod    = w_mag * tdr_pkg::DIV6_RECIP;
    assign w_quot    = w_prod[25:16];
    assign w_cap     = {1'b0, w_quot} + {4'd0, i_cfg.turn_dead_zone};
    assign w_cap_pos = $signed({1'b0, w_cap});
    assign w_cap_neg = -w_cap_pos;
    assign w_dz      = $signed({11'd0, i_cfg.turn_dead_zone});

    assign w_lvl    = {{2{i_level[7]}}, i_level};
    assign w_up     = tdr_pkg::push_up(w_lvl, i_cfg.turn_accel);
    assign w_down   = tdr_pkg::push_down(w_lvl, i_cfg.turn_accel);
    assign w_up_x   = {{2{w_up[9]}}, w_up};
    assign w_down_x = {{2{w_down[9]}}, w_down};

    always_comb begin
        if (w_int > w_dz) begin
            o_level = (w_up_x > w_cap_pos) ? w_cap_pos[7:0] : w_up[7:0];
        end else if (w_int < -w_dz) begin
            o_level = (w_down_x < w_cap_neg) ? w_cap_neg[7:0] : w_down[7:0];
        end else begin
            o_level = 8'sd0;
        end
    end

endmodule

### verif/tdr_tb_pkg.sv
// Scoreboard that predicts the drive levels, pitch and face, and checks each result transfer.
`timescale 1ns / 1ps
package tdr_tb_pkg;
    import tdr_pkg::*;

    localparam int LEVEL_TOP    = 127;
    localparam int PITCH_TOP    = 850;
    localparam int PITCH_PARK   = 550;
    localparam int TURN_DIVISOR = 6;

    class drive_scoreboard;
        t_cfg        cfg;
        int          strafe_lvl;
        int          move_lvl;
        int          turn_lvl;
        int          pitch_lvl;
        int          turn_sum;
        bit          link_on;
        logic [1:0]  face_now;
        int unsigned hold_left;
        t_out_item   expected_levels[$];
        int          errors;
        int          checked;

        function new();
            cfg = '{RST_MOOD_HOLD, RST_MOVE_ACCEL, RST_MOVE_BRAKE,
                    RST_TURN_DEAD, RST_TURN_ACCEL, RST_TURN_LIMIT};
            strafe_lvl = 0;
            move_lvl   = 0;
            turn_lvl   = 0;
            pitch_lvl  = 0;
            turn_sum   = 0;
            link_on    = 1'b0;
            face_now   = FACE_IDLE;
            hold_left  = 0;
            errors     = 0;
            checked    = 0;
        endfunction

        function int raise_level(int v, int step);
            return (v < LEVEL_TOP - step) ? v + step : LEVEL_TOP;
        endfunction

        function int lower_level(int v, int step);
            return (v > -(LEVEL_TOP - step)) ? v - step : -LEVEL_TOP;
        endfunction

        // The negative key acts first, then the positive key, so holding both
        // leaves the level roughly where it was before the item.
        function int slew_axis(int v, bit neg_key, bit pos_key);
            int accel;
            int brake;
            accel = cfg.move_accel;
            brake = cfg.move_brake;
            if (neg_key) begin
                v = lower_level(v, accel);
            end else if (v < 0) begin
                v = (v < -brake) ? v + brake : 0;
            end
            if (pos_key) begin
                v = raise_level(v, accel);
            end else if (v > 0) begin
                v = (v > brake) ? v - brake : 0;
            end
            return v;
        endfunction

        function void advance_tick(t_in_item it);
            int dx;
            int dy;
            int zone;
            int lim;
            int cap;
            dx   = $signed(it.mouse_dx);
            dy   = $signed(it.mouse_dy);
            zone = cfg.turn_dead_zone;
            lim  = cfg.turn_limit;
            if (hold_left != 0) begin
                hold_left--;
                if (hold_left == 0) begin
                    face_now = FACE_LINKED;
                end
            end
            strafe_lvl = slew_axis(strafe_lvl, it.key_left, it.key_right);
            move_lvl   = slew_axis(move_lvl, it.key_up, it.key_down);

            // Leaky integrator: lose half the current turn level, rounding toward zero.
            turn_sum = (2 * turn_sum - turn_lvl) / 2 + dx;
            if (turn_sum > lim) begin
                turn_sum = lim;
            end
            if (turn_sum < -lim) begin
                turn_sum = -lim;
            end

            if (turn_sum > zone) begin
                turn_lvl = raise_level(turn_lvl, cfg.turn_accel);
                cap = turn_sum / TURN_DIVISOR + zone;
                if (turn_lvl > cap) begin
                    turn_lvl = cap;
                end
            end else if (turn_sum < -zone) begin
                turn_lvl = lower_level(turn_lvl, cfg.turn_accel);
                cap = turn_sum / TURN_DIVISOR - zone;
                if (turn_lvl < cap) begin
                    turn_lvl = cap;
                end
            end else begin
                turn_lvl = 0;
            end

            pitch_lvl = pitch_lvl + dy;
            if (pitch_lvl > PITCH_TOP) begin
                pitch_lvl = PITCH_TOP;
            end else if (pitch_lvl < 0) begin
                pitch_lvl = 0;
            end
        endfunction

        // Called for every input transfer; queues the levels that must come back.
        function void note_item(t_in_item it);
            t_out_item want;
            case (it.kind)
                KIND_TICK: begin
                    if (link_on) begin
                        advance_tick(it);
                    end
                end
                KIND_STOP: begin
                    strafe_lvl = 0;
                    move_lvl   = 0;
                    turn_lvl   = 0;
                    turn_sum   = 0;
                    pitch_lvl  = PITCH_PARK;
                end
                KIND_LINK: begin
                    link_on  = it.link_up;
                    face_now = link_on ? FACE_LINKED : FACE_IDLE;
                end
                KIND_FACE: begin
                    if (it.mood == FACE_HAPPY || it.mood == FACE_ANGRY) begin
                        face_now  = it.mood;
                        hold_left = cfg.mood_hold_ticks;
                    end
                end
            endcase
            want.strafe_drive = strafe_lvl[7:0];
            want.move_drive   = move_lvl[7:0];
            want.turn_drive   = turn_lvl[7:0];
            want.camera_pitch = pitch_lvl[9:0];
            want.face         = face_now;
            expected_levels.push_back(want);
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("mismatch: %s", what);
        endtask

        task check_levels(t_out_item got);
            t_out_item want;
            checked++;
            if (expected_levels.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing expected", checked));
                return;
            end
            want = expected_levels.pop_front();
            if (got.strafe_drive !== want.strafe_drive) begin
                report_mismatch($sformatf("result %0d strafe_drive %0d, expected %0d",
                                          checked, got.strafe_drive, want.strafe_drive));
            end
            if (got.move_drive !== want.move_drive) begin
                report_mismatch($sformatf("result %0d move_drive %0d, expected %0d",
                                          checked, got.move_drive, want.move_drive));
            end
            if (got.turn_drive !== want.turn_drive) begin
                report_mismatch($sformatf("result %0d turn_drive %0d, expected %0d",
                                          checked, got.turn_drive, want.turn_drive));
            end
            if (got.camera_pitch !== want.camera_pitch) begin
                report_mismatch($sformatf("result %0d camera_pitch %0d, expected %0d",
                                          checked, got.camera_pitch, want.camera_pitch));
            end
            if (got.face !== want.face) begin
                report_mismatch($sformatf("result %0d face %0d, expected %0d",
                                          checked, got.face, want.face));
            end
        endtask

        function int pending();
            return expected_levels.size();
        endfunction
    endclass

endpackage

### verif/tb_top.sv
// Testbench top for the teleoperation drive ramp: clock, reset, stimulus and transfer monitor.
`timescale 1ns / 1ps
module tb_top;
    import tdr_pkg::*;
    import tdr_tb_pkg::*;

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 235;
    localparam int SETTLE_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT  = 4000;

    localparam logic [3:0] KEYS_NONE = 4'b0000;
    localparam logic [3:0] KEY_LEFT  = 4'b1000;
    localparam logic [3:0] KEY_RIGHT = 4'b0100;
    localparam logic [3:0] KEY_UP    = 4'b0010;
    localparam logic [3:0] KEY_DOWN  = 4'b0001;
    localparam logic [3:0] KEYS_ALL  = 4'b1111;

    logic              i_clk;
    logic              i_rst_n     = 1'b0;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [ADDR_W-1:0] paddr       = '0;
    logic [31:0]       pwdata      = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    t_in_item          i_in_data   = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_out_item         o_out_data;

    int                send_idle_pct = 0;
    int                stall_pct     = 0;
    int                quiet_cycles  = 0;
    logic [3:0]        held_keys     = '0;
    drive_scoreboard   sb;

    teleop_drive_ramp dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Transfer monitor and watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            sb.note_item(i_in_data);
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_levels(o_out_data);
        end
        if (i_rst_n && ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: %0d cycles without a transfer", WATCHDOG_LIMIT);
            $display("[teleop_drive_ramp] ERROR");
            $finish;
        end
    end

    function automatic t_in_item make_item(logic [1:0] kind, logic [3:0] keys, int dx, int dy,
                                           logic link, logic [1:0] mood);
        t_in_item c;
        c.kind = kind;
        {c.key_left, c.key_right, c.key_up, c.key_down} = keys;
        c.mouse_dx = 16'(dx);
        c.mouse_dy = 16'(dy);
        c.link_up  = link;
        c.mood     = mood;
        return c;
    endfunction

    // Mostly connected ticks with keys held over runs of items, so the ramps
    // reach saturation; the rest are stops, link changes and face events.
    function automatic t_in_item random_item();
        int         sel;
        int         dx;
        int         dy;
        logic [1:0] kind;
        logic [1:0] mood;
        logic [3:0] keys;
        for (int b = 0; b < 4; b++) begin
            if ($urandom_range(9) == 0) begin
                held_keys[b] = ~held_keys[b];
            end
        end
        sel = $urandom_range(99);
        kind = (sel < 80) ? KIND_TICK : (sel < 88) ? KIND_FACE : (sel < 96) ? KIND_LINK : KIND_STOP;
        sel = $urandom_range(99);
        if (sel < 60) begin
            dx = int'($urandom_range(80)) - 40;
        end else if (sel < 85) begin
            dx = int'($urandom_range(800)) - 400;
        end else if (sel < 95) begin
            dx = int'($urandom);
        end else begin
            dx = $urandom_range(1) ? 32767 : -32768;
        end
        sel = $urandom_range(99);
        if (sel < 70) begin
            dy = int'($urandom_range(60)) - 30;
        end else if (sel < 90) begin
            dy = int'($urandom_range(600)) - 300;
        end else begin
            dy = int'($urandom);
        end
        if ($urandom_range(9) == 0) begin
            mood = 2'($urandom_range(1));
        end else begin
            mood = $urandom_range(1) ? FACE_HAPPY : FACE_ANGRY;
        end
        keys = (kind == KIND_TICK) ? held_keys : 4'($urandom);
        return make_item(kind, keys, dx, dy, $urandom_range(99) < 85, mood);
    endfunction

    function automatic t_cfg settings_for(int phase);
        t_cfg c;
        case (phase)
            1: c = '{16'd0, 7'd0, 7'd0, 7'd0, 7'd0, 12'd1};
            2: c = '{16'd65535, 7'd126, 7'd127, 7'd127, 7'd126, 12'd4095};
            PHASES - 1: c = '{RST_MOOD_HOLD, RST_MOVE_ACCEL, RST_MOVE_BRAKE,
                              RST_TURN_DEAD, RST_TURN_ACCEL, RST_TURN_LIMIT};
            default: begin
                c.mood_hold_ticks = ($urandom_range(9) == 0) ? 16'($urandom)
                                                             : 16'($urandom_range(1, 30));
                c.move_accel      = 7'($urandom_range(0, 126));
                c.move_brake      = 7'($urandom_range(0, 127));
                c.turn_dead_zone  = 7'($urandom_range(0, 30));
                c.turn_accel      = 7'($urandom_range(0, 126));
                c.turn_limit      = 12'($urandom_range(1, 4095));
            end
        endcase
        return c;
    endfunction

    // Each task returns with none of its signal assignments still pending.
    task automatic send_item(input t_in_item cmd);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= cmd;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({index, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input t_cfg c);
        write_reg(REG_MOOD_HOLD, 32'(c.mood_hold_ticks));
        write_reg(REG_MOVE_ACCEL, 32'(c.move_accel));
        write_reg(REG_MOVE_BRAKE, 32'(c.move_brake));
        write_reg(REG_TURN_DEAD, 32'(c.turn_dead_zone));
        write_reg(REG_TURN_ACCEL, 32'(c.turn_accel));
        write_reg(REG_TURN_LIMIT, 32'(c.turn_limit));
        sb.cfg = c;
    endtask

    task automatic run_directed();
        // While the link is down a tick changes nothing, but stop and face events still act.
        send_item(make_item(KIND_TICK, KEYS_ALL, 32767, 32767, 1'b1, FACE_HAPPY));
        send_item(make_item(KIND_FACE, KEYS_NONE, 0, 0, 1'b0, FACE_HAPPY));
        send_item(make_item(KIND_STOP, KEYS_NONE, 0, 0, 1'b0, FACE_IDLE));
        send_item(make_item(KIND_LINK, KEYS_NONE, 0, 0, 1'b1, FACE_IDLE));
        send_item(make_item(KIND_TICK, KEY_LEFT, 32767, 32767, 1'b0, FACE_IDLE));
        send_item(make_item(KIND_TICK, KEY_LEFT | KEY_RIGHT, -32768, -32768, 1'b0, FACE_IDLE));
        send_item(make_item(KIND_TICK, KEY_RIGHT, 0, 300, 1'b0, FACE_IDLE));
        send_item(make_item(KIND_TICK, KEY_UP, 2, 5, 1'b0, FACE_IDLE));
        send_item(make_item(KIND_TICK, KEY_DOWN, -2, -5, 1'b0, FACE_IDLE));
        send_item(make_item(KIND_TICK, KEY_UP | KEY_DOWN, 5, 0, 1'b0, FACE_IDLE));
        send_item(make_item(KIND_TICK, KEYS_NONE, 0, 0, 1'b0, FACE_IDLE));
        send_item(make_item(KIND_FACE, KEYS_NONE, 0, 0, 1'b1, FACE_ANGRY));
        send_item(make_item(KIND_FACE, KEYS_ALL, -1, -1, 1'b1, 2'd0));
        send_item(make_item(KIND_FACE, KEYS_ALL, -1, -1, 1'b0, 2'd1));
        send_item(make_item(KIND_TICK, KEYS_ALL, -1, 1, 1'b1, FACE_ANGRY));
        send_item(make_item(KIND_LINK, KEYS_NONE, 0, 0, 1'b0, FACE_HAPPY));
        send_item(make_item(KIND_TICK, KEY_RIGHT, 500, 500, 1'b0, FACE_IDLE));
        send_item(make_item(KIND_LINK, KEYS_ALL, 0, 0, 1'b1, FACE_ANGRY));
        send_item(make_item(KIND_STOP, KEYS_ALL, 32767, -32768, 1'b1, FACE_ANGRY));
        // Just past the dead zone on each side.
        send_item(make_item(KIND_TICK, KEYS_NONE, 4, 0, 1'b0, FACE_IDLE));
        send_item(make_item(KIND_TICK, KEYS_NONE, -8, 0, 1'b0, FACE_IDLE));
    endtask

    initial begin
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                drain_results();
                apply_settings(settings_for(phase));
            end
            case (phase % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 84;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 84;
                end
                default: begin
                    send_idle_pct = 22;
                    stall_pct     = 22;
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Hold the input off mid-phase while the stalled output empties.
                if (phase == 2 && n == ITEMS_PER_PHASE / 2) begin
                    drain_results();
                end
                send_item(random_item());
            end
        end
        drain_results();
        if (sb.pending() != 0) begin
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
        end
        if (sb.errors == 0) begin
            $display("[teleop_drive_ramp] OK");
        end else begin
            $display("[teleop_drive_ramp] ERROR");
        end
        $finish;
    end

endmodule
